// ----- hdl/gcwp_pkg.sv -----
package gcwp_pkg;

    // Fixed-point scaling of the axis words and width of an axis value.
    localparam int DECIMALS    = 3;
    localparam int VALUE_WIDTH = 32;

    // Magnitude accumulator and the wide sum that checks it for saturation.
    localparam int ACC_W = VALUE_WIDTH - 1;
    localparam int SUM_W = (VALUE_WIDTH + 4 > 28) ? VALUE_WIDTH + 4 : 28;
    localparam logic [SUM_W-1:0] MAG_MAX = (SUM_W'(1) << ACC_W) - SUM_W'(1);

    localparam int CODE_W = 16;
    localparam logic [CODE_W+3:0] CODE_MAX = (20'(1) << CODE_W) - 20'(1);

    localparam int AXES   = 5;
    localparam int AXIS_W = 3;
    localparam logic [AXIS_W-1:0] AX_X = 3'd0;
    localparam logic [AXIS_W-1:0] AX_Y = 3'd1;
    localparam logic [AXIS_W-1:0] AX_Z = 3'd2;
    localparam logic [AXIS_W-1:0] AX_E = 3'd3;
    localparam logic [AXIS_W-1:0] AX_F = 3'd4;

    // Lower-case letters; a byte is folded by setting bit 5 before compare.
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_Y     = 8'h79;
    localparam logic [7:0] CH_Z     = 8'h7a;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_CODE = 3'd1,
        PH_SIGN = 3'd2,
        PH_INT  = 3'd3,
        PH_FRAC = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       line_end;
    } cmd_word_t;

    typedef struct packed {
        logic [CODE_W-1:0]             code_number;
        logic signed [VALUE_WIDTH-1:0] x_value;
        logic signed [VALUE_WIDTH-1:0] y_value;
        logic signed [VALUE_WIDTH-1:0] z_value;
        logic signed [VALUE_WIDTH-1:0] extrude_value;
        logic signed [VALUE_WIDTH-1:0] feed_value;
        logic                          has_x_word;
        logic                          has_y_word;
        logic                          has_z_word;
        logic                          has_extrude_word;
        logic                          has_feed_word;
        logic                          value_overflow;
    } res_word_t;

    // Ten to the power e, for e up to 6; zero for anything larger.
    function automatic logic [23:0] pow10(input logic [2:0] e);
        logic [23:0] r;
        case (e)
            3'd0:    r = 24'd1;
            3'd1:    r = 24'd10;
            3'd2:    r = 24'd100;
            3'd3:    r = 24'd1000;
            3'd4:    r = 24'd10000;
            3'd5:    r = 24'd100000;
            3'd6:    r = 24'd1000000;
            default: r = 24'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/gcode_word_parser.sv -----
// G-code word parser. Feed one character per word on the cmd channel and
// mark the line's final character with line_end; one result word follows
// on the res channel carrying the last G code number (unsigned, held at
// 65535) and the last X, Y, Z, E and F values of the line, each signed and
// scaled by 10^DECIMALS (3 by default), with a has_* flag per letter and
// a sticky overflow flag for any saturated number. Letters match in either
// case, extra fraction digits truncate, and bytes outside a word are
// skipped. The parse state and the multiply-by-ten-add of the accumulator
// update at the accept edge, so a character can be taken every clock unless
// cmd_stall holds a line end. The edge that accepts line_end loads the result
// into the output register, so it is offered in the next cycle; while it
// waits under stall, ordinary characters keep flowing and only the next
// line_end character is held.
module gcode_word_parser
    import gcwp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,

    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_word_t cmd_word,

    output logic      res_valid,
    input  logic      res_stall,
    output res_word_t res_word
);

    // Parse state.
    phase_t                phase_reg, phase_next;
    logic [AXIS_W-1:0]     active_reg, active_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [2:0]            frac_cnt_reg, frac_cnt_next;
    logic                  neg_reg, neg_next;
    logic [CODE_W-1:0]     code_reg, code_next;
    logic [AXES-1:0]       present_reg, present_next;
    logic                  ovf_reg, ovf_next;

    // Axis values; an axis without its present flag reads as zero.
    logic [VALUE_WIDTH-1:0] axis_reg [AXES];

    logic                  res_valid_reg, res_valid_next;
    res_word_t             res_word_reg, res_word_next;

    // Per-character decode.
    logic                  accept;
    logic                  last;
    logic [7:0]            ch;
    logic [7:0]            ch_low;
    logic                  is_digit;
    logic [3:0]            digit;
    logic                  handled;
    logic                  commit;
    logic [VALUE_WIDTH-1:0] commit_val;
    logic [VALUE_WIDTH-1:0] axis_view [AXES];
    logic [CODE_W+3:0]     code_prod;

    // Accumulator step.
    logic                  acc_frac_mode;
    logic [ACC_W-1:0]      acc_step;
    logic                  acc_sat;

    assign ch       = cmd_word.char_byte;
    assign last     = cmd_word.line_end;
    assign ch_low   = ch | 8'h20;
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign digit    = is_digit ? 4'(ch - CH_ZERO) : 4'd0;

    // Hold only a line end while the previous result is still stalled.
    assign cmd_stall = res_valid_reg && res_stall && last;
    assign accept    = cmd_valid && !cmd_stall;

    assign acc_frac_mode = (phase_reg == PH_FRAC);

    gcwp_accum u_accum (
        .acc       (acc_reg),
        .digit     (digit),
        .frac_mode (acc_frac_mode),
        .frac_cnt  (frac_cnt_reg),
        .acc_sat   (acc_step),
        .sat       (acc_sat)
    );

    assign code_prod = (20'(code_reg) << 3) + (20'(code_reg) << 1) + 20'(digit);

    // Next parse state for the character at the input.
    always_comb
    begin
        phase_next    = phase_reg;
        active_next   = active_reg;
        acc_next      = acc_reg;
        frac_cnt_next = frac_cnt_reg;
        neg_next      = neg_reg;
        code_next     = code_reg;
        present_next  = present_reg;
        ovf_next      = ovf_reg;
        handled       = 1'b0;

        unique case (phase_reg)
            PH_CODE:
            begin
                if (is_digit)
                begin
                    handled = 1'b1;
                    if (code_prod > CODE_MAX)
                    begin
                        code_next = CODE_MAX[CODE_W-1:0];
                        ovf_next  = 1'b1;
                    end
                    else
                    begin
                        code_next = code_prod[CODE_W-1:0];
                    end
                end
            end
            PH_SIGN, PH_INT:
            begin
                if ((phase_reg == PH_SIGN) && (ch == CH_MINUS))
                begin
                    neg_next   = 1'b1;
                    phase_next = PH_INT;
                    handled    = 1'b1;
                end
                else if (is_digit)
                begin
                    acc_next   = acc_step;
                    ovf_next   = ovf_reg | acc_sat;
                    phase_next = PH_INT;
                    handled    = 1'b1;
                end
                else if (ch == CH_DOT)
                begin
                    phase_next = PH_FRAC;
                    handled    = 1'b1;
                end
            end
            PH_FRAC:
            begin
                if (is_digit)
                begin
                    handled = 1'b1;
                    // Drop digits past the scale.
                    if (32'(frac_cnt_reg) < DECIMALS)
                    begin
                        acc_next      = acc_step;
                        ovf_next      = ovf_reg | acc_sat;
                        frac_cnt_next = frac_cnt_reg + 3'd1;
                    end
                end
            end
            PH_IDLE:
            begin
            end
            default:
            begin
            end
        endcase

        // A character that does not continue a number is looked at as a letter.
        if (!handled)
        begin
            phase_next = PH_IDLE;
            if (ch_low == CH_G)
            begin
                code_next  = '0;
                phase_next = PH_CODE;
            end
            else if ((ch_low == CH_X) || (ch_low == CH_Y) || (ch_low == CH_Z) ||
                     (ch_low == CH_E) || (ch_low == CH_F))
            begin
                unique case (ch_low)
                    CH_X:    active_next = AX_X;
                    CH_Y:    active_next = AX_Y;
                    CH_Z:    active_next = AX_Z;
                    CH_E:    active_next = AX_E;
                    default: active_next = AX_F;
                endcase
                acc_next                  = '0;
                frac_cnt_next             = '0;
                neg_next                  = 1'b0;
                present_next[active_next] = 1'b1;
                phase_next                = PH_SIGN;
            end
        end
    end

    // Write the running value of the open axis word on every accepted character while it is open.
    always_comb
    begin
        commit     = (phase_next == PH_SIGN) || (phase_next == PH_INT) ||
                     (phase_next == PH_FRAC);
        commit_val = neg_next ? (VALUE_WIDTH'(0) - VALUE_WIDTH'(acc_next))
                              : VALUE_WIDTH'(acc_next);
        for (int i = 0; i < AXES; i++)
        begin
            if (!present_next[i])
            begin
                axis_view[i] = '0;
            end
            else if (commit && (active_next == AXIS_W'(i)))
            begin
                axis_view[i] = commit_val;
            end
            else
            begin
                axis_view[i] = axis_reg[i];
            end
        end
    end

    // Result word and output handshake.
    always_comb
    begin
        res_word_next                  = res_word_reg;
        res_word_next.code_number      = code_next;
        res_word_next.x_value          = axis_view[AX_X];
        res_word_next.y_value          = axis_view[AX_Y];
        res_word_next.z_value          = axis_view[AX_Z];
        res_word_next.extrude_value    = axis_view[AX_E];
        res_word_next.feed_value       = axis_view[AX_F];
        res_word_next.has_x_word       = present_next[AX_X];
        res_word_next.has_y_word       = present_next[AX_Y];
        res_word_next.has_z_word       = present_next[AX_Z];
        res_word_next.has_extrude_word = present_next[AX_E];
        res_word_next.has_feed_word    = present_next[AX_F];
        res_word_next.value_overflow   = ovf_next;

        res_valid_next = res_valid_reg && res_stall;
        if (accept && last)
        begin
            res_valid_next = 1'b1;
        end
    end

    // Advance the parse state on every accepted character; clear it after a line end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            active_reg    <= '0;
            acc_reg       <= '0;
            frac_cnt_reg  <= '0;
            neg_reg       <= 1'b0;
            code_reg      <= '0;
            present_reg   <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (accept)
            begin
                if (last)
                begin
                    phase_reg    <= PH_IDLE;
                    active_reg   <= '0;
                    acc_reg      <= '0;
                    frac_cnt_reg <= '0;
                    neg_reg      <= 1'b0;
                    code_reg     <= '0;
                    present_reg  <= '0;
                    ovf_reg      <= 1'b0;
                end
                else
                begin
                    phase_reg    <= phase_next;
                    active_reg   <= active_next;
                    acc_reg      <= acc_next;
                    frac_cnt_reg <= frac_cnt_next;
                    neg_reg      <= neg_next;
                    code_reg     <= code_next;
                    present_reg  <= present_next;
                    ovf_reg      <= ovf_next;
                end
            end
        end
    end

    // Axis store and result register carry payload only.
    always_ff @(posedge clk)
    begin
        if (accept && commit)
        begin
            axis_reg[active_next] <= commit_val;
        end
        if (accept && last)
        begin
            res_word_reg <= res_word_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

endmodule

// ----- hdl/gcwp_accum.sv -----
module gcwp_accum
    import gcwp_pkg::*;
(
    input  logic [ACC_W-1:0] acc,
    input  logic [3:0]       digit,
    input  logic             frac_mode,
    input  logic [2:0]       frac_cnt,
    output logic [ACC_W-1:0] acc_sat,
    output logic             sat
);

    logic [23:0]      weight;
    logic [SUM_W-1:0] add;
    logic [SUM_W-1:0] base;
    logic [SUM_W-1:0] sum;

    // Integer digit: acc * 10 + d * 10^DECIMALS.
    // Fraction digit: acc + d * 10^(DECIMALS - 1 - count).
    always_comb
    begin
        weight = frac_mode ? pow10(3'(DECIMALS - 1) - frac_cnt) : pow10(3'(DECIMALS));
        add    = SUM_W'(digit) * SUM_W'(weight);
        if (frac_mode)
        begin
            base = SUM_W'(acc);
        end
        else
        begin
            base = (SUM_W'(acc) << 3) + (SUM_W'(acc) << 1);
        end
        sum     = base + add;
        sat     = (sum > MAG_MAX);
        acc_sat = sat ? MAG_MAX[ACC_W-1:0] : sum[ACC_W-1:0];
    end

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
    import gcwp_pkg::*;

    // Run length, stretch of the long result hold-off, final drain wait and code ceiling.
    localparam int CYCLE_LIMIT     = 200000;
    localparam int RES_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CODE_CEILING    = 65535;

    localparam logic [63:0] MAG_LIMIT = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CASE_BIT = 8'h20;

    typedef logic [7:0] char_q_t[$];

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_word_t cmd_word  = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_word_t res_word;

    gcode_word_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Percent of cycles in which the sender idles and the receiver stalls.
    int cmd_idle_pct  = 20;
    int res_stall_pct = 20;

    // A hold-off is requested by bumping hold_requests; the receiver owns the count.
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    int error_count   = 0;
    int chars_sent    = 0;
    int lines_checked = 0;
    int cycle_count   = 0;

    // Parsed lines still waiting for their result word, oldest first.
    res_word_t line_results_q[$];

    // Line state as the parser is expected to hold it.
    phase_t                 ln_phase;
    logic [AXIS_W-1:0]      ln_axis;
    logic [63:0]            ln_mag;
    int                     ln_frac_digits;
    logic                   ln_negative;
    logic [31:0]            ln_code;
    logic [VALUE_WIDTH-1:0] ln_axis_value [AXES];
    logic [AXES-1:0]        ln_axis_seen;
    logic                   ln_overflow;

    // ------------------------------------------------------------------
    // Line model
    // ------------------------------------------------------------------

    task automatic clear_line_model();
        ln_phase       = PH_IDLE;
        ln_axis        = AX_X;
        ln_mag         = '0;
        ln_frac_digits = 0;
        ln_negative    = 1'b0;
        ln_code        = '0;
        ln_overflow    = 1'b0;
        ln_axis_seen   = '0;
        for (int i = 0; i < AXES; i++)
            ln_axis_value[i] = '0;
    endtask

    function automatic logic [63:0] ten_to(input int e);
        logic [63:0] r;
        r = 64'd1;
        for (int i = 0; i < e; i++)
            r = r * 64'd10;
        return r;
    endfunction

    // Multiply-add of the magnitude, held at the largest magnitude on overflow.
    task automatic accumulate(input logic [63:0] mul, input logic [63:0] add);
        logic [63:0] room;
        room = (add > MAG_LIMIT) ? MAG_LIMIT : add;
        if (ln_mag > (MAG_LIMIT - room) / mul || add > MAG_LIMIT)
        begin
            ln_mag      = MAG_LIMIT;
            ln_overflow = 1'b1;
        end
        else
        begin
            ln_mag = ln_mag * mul + add;
        end
    endtask

    // Advance the line model by one accepted character; queue the result on line end.
    task automatic parse_char(input logic [7:0] c, input logic last);
        logic        digit;
        logic [63:0] d;
        logic        handled;
        logic [31:0] n;
        logic [7:0]  folded;
        int          axis;
        logic [63:0] signed_mag;
        res_word_t   line_result;

        digit   = (c >= CH_ZERO) && (c <= CH_NINE);
        d       = digit ? 64'(c - CH_ZERO) : 64'd0;
        handled = 1'b0;

        case (ln_phase)
            PH_CODE:
            begin
                if (digit)
                begin
                    n = ln_code * 32'd10 + 32'(d);
                    if (n > CODE_CEILING)
                    begin
                        n           = CODE_CEILING;
                        ln_overflow = 1'b1;
                    end
                    ln_code = n;
                    handled = 1'b1;
                end
            end
            PH_SIGN, PH_INT:
            begin
                if (ln_phase == PH_SIGN && c == CH_MINUS)
                begin
                    ln_negative = 1'b1;
                    ln_phase    = PH_INT;
                    handled     = 1'b1;
                end
                else if (digit)
                begin
                    accumulate(64'd10, d * ten_to(DECIMALS));
                    ln_phase = PH_INT;
                    handled  = 1'b1;
                end
                else if (c == CH_DOT)
                begin
                    ln_phase = PH_FRAC;
                    handled  = 1'b1;
                end
            end
            PH_FRAC:
            begin
                if (digit)
                begin
                    // Drop fraction digits past the fixed-point scale.
                    if (ln_frac_digits < DECIMALS)
                    begin
                        accumulate(64'd1, d * ten_to(DECIMALS - 1 - ln_frac_digits));
                        ln_frac_digits++;
                    end
                    handled = 1'b1;
                end
            end
            default: ;
        endcase

        // The byte that ends a number is looked at again as a word letter.
        if (!handled)
        begin
            folded   = c | CASE_BIT;
            ln_phase = PH_IDLE;
            case (folded)
                CH_X:    axis = AX_X;
                CH_Y:    axis = AX_Y;
                CH_Z:    axis = AX_Z;
                CH_E:    axis = AX_E;
                CH_F:    axis = AX_F;
                default: axis = -1;
            endcase
            if (folded == CH_G)
            begin
                ln_code  = '0;
                ln_phase = PH_CODE;
            end
            else if (axis >= 0)
            begin
                ln_axis            = AXIS_W'(axis);
                ln_mag             = '0;
                ln_frac_digits     = 0;
                ln_negative        = 1'b0;
                ln_axis_seen[axis] = 1'b1;
                ln_phase           = PH_SIGN;
            end
        end

        if (ln_phase inside {PH_SIGN, PH_INT, PH_FRAC})
        begin
            signed_mag             = ln_negative ? (64'd0 - ln_mag) : ln_mag;
            ln_axis_value[ln_axis] = signed_mag[VALUE_WIDTH-1:0];
        end

        if (last)
        begin
            line_result.code_number      = ln_code[CODE_W-1:0];
            line_result.x_value          = ln_axis_value[AX_X];
            line_result.y_value          = ln_axis_value[AX_Y];
            line_result.z_value          = ln_axis_value[AX_Z];
            line_result.extrude_value    = ln_axis_value[AX_E];
            line_result.feed_value       = ln_axis_value[AX_F];
            line_result.has_x_word       = ln_axis_seen[AX_X];
            line_result.has_y_word       = ln_axis_seen[AX_Y];
            line_result.has_z_word       = ln_axis_seen[AX_Z];
            line_result.has_extrude_word = ln_axis_seen[AX_E];
            line_result.has_feed_word    = ln_axis_seen[AX_F];
            line_result.value_overflow   = ln_overflow;
            line_results_q.push_back(line_result);
            clear_line_model();
        end
    endtask

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------

    // Offer one character word at the falling edge, idling at random first,
    // and hold it until the parser takes it at a rising edge.
    task automatic send_char(input logic [7:0] c, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < cmd_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_word  <= '{char_byte: c, line_end: last};
        do
            @(posedge clk);
        while (cmd_stall);
        chars_sent++;
        parse_char(c, last);
    endtask

    task automatic send_line(input char_q_t line);
        foreach (line[i])
            send_char(line[i], i == line.size() - 1);
    endtask

    task automatic send_text(input string s, input logic end_line);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], end_line && i == s.len() - 1);
    endtask

    // Drop valid and wait until every queued line has its result back.
    task automatic wait_results_drained();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (line_results_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] random_digit();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    // Mostly well-formed lines of G and axis words with random content; some
    // lines are pure noise, and stray signs and bytes break up the rest.
    task automatic build_random_line(ref char_q_t line);
        logic [7:0] letter;
        int         pick;
        int         n_digits;

        line.delete();
        if ($urandom_range(99) < 12)
        begin
            repeat ($urandom_range(1, 12))
                line.push_back(8'($urandom_range(255)));
            return;
        end

        repeat ($urandom_range(1, 6))
        begin
            pick = $urandom_range(5);
            case (pick)
                0:       letter = CH_G;
                1:       letter = CH_X;
                2:       letter = CH_Y;
                3:       letter = CH_Z;
                4:       letter = CH_E;
                default: letter = CH_F;
            endcase
            if ($urandom_range(1))
                letter = letter & ~CASE_BIT;
            line.push_back(letter);

            if (pick == 0)
            begin
                n_digits = ($urandom_range(99) < 8) ? $urandom_range(5, 7) : $urandom_range(0, 3);
                repeat (n_digits)
                    line.push_back(random_digit());
            end
            else
            begin
                if ($urandom_range(1))
                    line.push_back(CH_MINUS);
                n_digits = ($urandom_range(99) < 6) ? $urandom_range(6, 10) : $urandom_range(0, 4);
                repeat (n_digits)
                    line.push_back(random_digit());
                if ($urandom_range(99) < 60)
                begin
                    line.push_back(CH_DOT);
                    repeat ($urandom_range(0, 5))
                        line.push_back(random_digit());
                end
            end

            if ($urandom_range(99) < 8)
                line.push_back(CH_MINUS);
            pick = $urandom_range(99);
            if (pick < 60)
                line.push_back(CH_SPACE);
            else if (pick < 75)
                line.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic send_random_lines(input int n_chars);
        char_q_t line;
        int      start;
        start = chars_sent;
        while (chars_sent - start < n_chars)
        begin
            build_random_line(line);
            send_line(line);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Stall at random, or for a whole hold-off once one is requested.
    always @(negedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served = hold_requests;
            hold_left   = RES_HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            res_stall <= 1'b1;
        end
        else
        begin
            res_stall <= ($urandom_range(99) < res_stall_pct);
        end
    end

    task automatic check_field(input string field, input longint expected, input longint actual);
        if (expected != actual)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, expected, actual);
            error_count++;
        end
    endtask

    // Compare each accepted result word with the oldest pending line.
    always @(posedge clk)
    begin : result_checker
        res_word_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (line_results_q.size() == 0)
            begin
                $display("%0t: result word with no line pending, got %p", $time, res_word);
                error_count++;
            end
            else
            begin
                want = line_results_q.pop_front();
                check_field("code_number",      want.code_number,      res_word.code_number);
                check_field("x_value",          want.x_value,          res_word.x_value);
                check_field("y_value",          want.y_value,          res_word.y_value);
                check_field("z_value",          want.z_value,          res_word.z_value);
                check_field("extrude_value",    want.extrude_value,    res_word.extrude_value);
                check_field("feed_value",       want.feed_value,       res_word.feed_value);
                check_field("has_x_word",       want.has_x_word,       res_word.has_x_word);
                check_field("has_y_word",       want.has_y_word,       res_word.has_y_word);
                check_field("has_z_word",       want.has_z_word,       res_word.has_z_word);
                check_field("has_extrude_word", want.has_extrude_word, res_word.has_extrude_word);
                check_field("has_feed_word",    want.has_feed_word,    res_word.has_feed_word);
                check_field("value_overflow",   want.value_overflow,   res_word.value_overflow);
                lines_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-built lines: empty line on a NUL, code saturation, a bare word
    // letter, axis saturation, negative zero, a 0xFF byte, truncated fraction,
    // a repeated letter and a minus sign that ends a number.
    task automatic test_directed_lines();
        send_char(8'h00, 1'b1);
        send_text("g70000Z", 1'b1);
        send_text("E9999999", 1'b0);
        send_char(8'hFF, 1'b0);
        send_text("F-0", 1'b1);
        send_text("x.1239X7-2y", 1'b1);
    endtask

    task automatic test_random_lines();
        send_random_lines(1100);
    endtask

    // Run a stretch with both sides at full rate.
    task automatic test_full_rate();
        cmd_idle_pct  = 0;
        res_stall_pct = 0;
        send_random_lines(250);
        cmd_idle_pct  = 20;
        res_stall_pct = 20;
    endtask

    // Hold the result side off while lines keep coming, so a second line end
    // backs up into cmd_stall.
    task automatic test_result_hold_off();
        cmd_idle_pct = 0;
        hold_requests++;
        send_random_lines(120);
        cmd_idle_pct = 20;
    endtask

    // Pause the sender until the pipeline is empty between short bursts.
    task automatic test_drain_pauses();
        repeat (5)
        begin
            send_random_lines(30);
            wait_results_drained();
        end
    endtask

    initial
    begin
        clear_line_model();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_lines();
        test_random_lines();
        test_full_rate();
        test_result_hold_off();
        test_drain_pauses();

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d characters sent, %0d line results compared", chars_sent,
                 lines_checked);
        $display("summary: G and axis words, signs, fractions, saturation, noise, back-pressure");
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
